### src/tdpt_pkg.sv
// Shared widths, constants, state codes and link structs for the
// trial-division primality tester. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

  // Width of the value field, two's complement.
  localparam int VALUE_WIDTH = 32;
  // Magnitude bits: sign bit is clear for every value that reaches the divider.
  localparam int MAG_W       = VALUE_WIDTH - 1;
  // Bit counter for one division, counts MAG_W-1 down to 0.
  localparam int CNT_W       = $clog2(MAG_W);

  localparam logic [MAG_W-1:0] VAL_TWO    = MAG_W'(2);
  localparam logic [MAG_W-1:0] VAL_THREE  = MAG_W'(3);
  localparam logic [MAG_W-1:0] FIRST_CAND = MAG_W'(5);
  localparam logic [MAG_W-1:0] CAND_GAP   = MAG_W'(2);
  localparam logic [MAG_W-1:0] CAND_STEP  = MAG_W'(6);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV3 = 5'b00010,
    ST_DIVA = 5'b00100,
    ST_DIVB = 5'b01000,
    ST_FIN  = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quot;
    logic             rem_zero;
  } div_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic flag;
  } seq_sts_t;

endpackage

`default_nettype wire

### src/tdpt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_div (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  tdpt_pkg::div_req_t req_i,
  output tdpt_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [tdpt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  // dividend shifts out at the top while quotient bits shift in at the bottom
  logic [tdpt_pkg::MAG_W-1:0]   dq_q, dq_d;
  logic [tdpt_pkg::MAG_W-1:0]   rem_q, rem_d;
  logic [tdpt_pkg::MAG_W-1:0]   dsr_q, dsr_d;
  logic [tdpt_pkg::MAG_W:0]     partial;
  logic [tdpt_pkg::MAG_W:0]     diff;
  logic                         ge;

  assign partial = {rem_q, dq_q[tdpt_pkg::MAG_W-1]};
  assign diff    = partial - {1'b0, dsr_q};
  assign ge      = partial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = tdpt_pkg::CNT_W'(tdpt_pkg::MAG_W - 1);
      dq_d   = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[tdpt_pkg::MAG_W-1:0] : partial[tdpt_pkg::MAG_W-1:0];
      dq_d  = {dq_q[tdpt_pkg::MAG_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quot     = dq_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

### src/tdpt_seq.sv
// Sequencer: screens trivial values, divides by 3, then walks the
// 6k-1 / 6k+1 divisors through the serial divider. Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_seq (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start_i,
  input  wire  [tdpt_pkg::VALUE_WIDTH-1:0]      value_i,
  input  wire                                   ack_i,
  output tdpt_pkg::seq_sts_t                    sts_o,
  output tdpt_pkg::div_req_t                    req_o,
  input  tdpt_pkg::div_rsp_t                    rsp_i
);

  tdpt_pkg::seq_state_e           state_q, state_d;
  logic [tdpt_pkg::MAG_W-1:0]     val_q, val_d;
  logic [tdpt_pkg::MAG_W-1:0]     cand_q, cand_d;
  logic                           flag_q, flag_d;
  logic [tdpt_pkg::MAG_W-1:0]     mag;

  assign mag = value_i[tdpt_pkg::MAG_W-1:0];

  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    cand_d       = cand_q;
    flag_d       = flag_q;
    req_o.start  = 1'b0;
    req_o.dividend = (state_q == tdpt_pkg::ST_IDLE) ? mag : val_q;
    req_o.divisor  = '0;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (start_i) begin
          val_d = mag;
          if (value_i[tdpt_pkg::VALUE_WIDTH-1] || mag < tdpt_pkg::VAL_TWO) begin
            flag_d  = 1'b0;
            state_d = tdpt_pkg::ST_FIN;
          end else if (mag == tdpt_pkg::VAL_TWO || mag == tdpt_pkg::VAL_THREE) begin
            flag_d  = 1'b1;
            state_d = tdpt_pkg::ST_FIN;
          end else if (!mag[0]) begin
            flag_d  = 1'b0;
            state_d = tdpt_pkg::ST_FIN;
          end else begin
            req_o.start   = 1'b1;
            req_o.divisor = tdpt_pkg::VAL_THREE;
            state_d       = tdpt_pkg::ST_DIV3;
          end
        end
      end
      tdpt_pkg::ST_DIV3: begin
        if (rsp_i.done) begin
          if (rsp_i.rem_zero) begin
            flag_d  = 1'b0;
            state_d = tdpt_pkg::ST_FIN;
          end else begin
            cand_d        = tdpt_pkg::FIRST_CAND;
            req_o.start   = 1'b1;
            req_o.divisor = tdpt_pkg::FIRST_CAND;
            state_d       = tdpt_pkg::ST_DIVA;
          end
        end
      end
      tdpt_pkg::ST_DIVA: begin
        // quotient of v / i doubles as the bound check i <= v / i
        if (rsp_i.done) begin
          if (cand_q > rsp_i.quot) begin
            flag_d  = 1'b1;
            state_d = tdpt_pkg::ST_FIN;
          end else if (rsp_i.rem_zero) begin
            flag_d  = 1'b0;
            state_d = tdpt_pkg::ST_FIN;
          end else begin
            req_o.start   = 1'b1;
            req_o.divisor = cand_q + tdpt_pkg::CAND_GAP;
            state_d       = tdpt_pkg::ST_DIVB;
          end
        end
      end
      tdpt_pkg::ST_DIVB: begin
        if (rsp_i.done) begin
          if (rsp_i.rem_zero) begin
            flag_d  = 1'b0;
            state_d = tdpt_pkg::ST_FIN;
          end else begin
            cand_d        = cand_q + tdpt_pkg::CAND_STEP;
            req_o.start   = 1'b1;
            req_o.divisor = cand_q + tdpt_pkg::CAND_STEP;
            state_d       = tdpt_pkg::ST_DIVA;
          end
        end
      end
      tdpt_pkg::ST_FIN: begin
        if (ack_i) begin
          state_d = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    cand_q <= cand_d;
    flag_q <= flag_d;
  end

  assign sts_o.idle = (state_q == tdpt_pkg::ST_IDLE);
  assign sts_o.done = (state_q == tdpt_pkg::ST_FIN);
  assign sts_o.flag = flag_q;

endmodule

`default_nettype wire

### src/trial_division_primality_test.sv
// Top level of the trial-division primality tester: request handshake,
// result register, sequencer and serial divider. Depends on tdpt_pkg,
// tdpt_seq and tdpt_div.
`timescale 1ns / 1ps
`default_nettype none

// Tests one signed value per request and returns one prime_flag for it.
// Negative values, 0 and 1 are not prime; 2 and 3 are; other even values
// are rejected at once. Anything else is divided by 3 and then by the
// pairs i, i+2 for i = 5, 11, 17, ... while i <= v / i, the quotient of the
// first division of each pair giving the bound. All division runs through
// one restoring divider that produces one quotient bit per cycle. Trivial
// values go straight to the finish state and from there into the result
// register. A prime needs 2 + 2 * rounds divisions (rounds being the i, i+2
// pairs fully tried), about 7700 rounds for the largest 31-bit primes. One
// request is worked on at a time:
// value_stall_o is high from acceptance until the result has moved into the
// output register, which holds it while result_stall_i is high, so the next
// request can start while the previous result waits.

module trial_division_primality_test (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  value_valid_i,
  output logic                                 value_stall_o,
  input  wire  [tdpt_pkg::VALUE_WIDTH-1:0]     value_i,
  output logic                                 result_valid_o,
  input  wire                                  result_stall_i,
  output logic                                 prime_flag_o
);

  tdpt_pkg::seq_sts_t sts;
  tdpt_pkg::div_req_t div_req;
  tdpt_pkg::div_rsp_t div_rsp;

  logic start;
  logic load;
  logic out_valid_q, out_valid_d;
  logic flag_q, flag_d;

  // A request enters only when the sequencer is idle.
  assign start         = value_valid_i && sts.idle;
  assign value_stall_o = !sts.idle;

  // Result register takes the verdict when empty or being drained this cycle.
  assign load        = sts.done && (!out_valid_q || !result_stall_i);
  assign out_valid_d = load || (out_valid_q && result_stall_i);
  assign flag_d      = load ? sts.flag : flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
  end

  assign result_valid_o = out_valid_q;
  assign prime_flag_o   = flag_q;

  tdpt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .ack_i   (load),
    .sts_o   (sts),
    .req_o   (div_req),
    .rsp_i   (div_rsp)
  );

  tdpt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

`default_nettype wire

### src/tdpt_chk.sv
// Port-level checker for trial_division_primality_test, with its bind.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_chk (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              value_valid_i,
  input wire                              value_stall_o,
  input wire [tdpt_pkg::VALUE_WIDTH-1:0]  value_i,
  input wire                              result_valid_o,
  input wire                              result_stall_i,
  input wire                              prime_flag_o
);

  logic req_acc;
  logic trivial_no;
  logic trivial_yes;

  assign req_acc     = value_valid_i && !value_stall_o;
  assign trivial_no  = value_i[tdpt_pkg::VALUE_WIDTH-1] || !value_i[0] ||
                       value_i == tdpt_pkg::VALUE_WIDTH'(1);
  assign trivial_yes = value_i == tdpt_pkg::VALUE_WIDTH'(2) ||
                       value_i == tdpt_pkg::VALUE_WIDTH'(3);

  // one request at a time: the block goes busy after taking one
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> value_stall_o)
    else $error("request taken while block still idle");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(prime_flag_o))
    else $error("stalled result dropped or changed");

  a_fast_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !result_valid_o && trivial_no && !trivial_yes
      |-> ##2 (result_valid_o && !prime_flag_o))
    else $error("trivial composite not reported in time");

  a_fast_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !result_valid_o && trivial_yes |-> ##2 (result_valid_o && prime_flag_o))
    else $error("2 or 3 not reported prime in time");

endmodule

bind trial_division_primality_test tdpt_chk u_tdpt_chk (.*);

`default_nettype wire
